/* hdl/awarp_pkg.sv */
// ----------------------------------------------------------------------------
// awarp_pkg
// shared constants, codes and item types of the affine backward warp
// ----------------------------------------------------------------------------
package awarp_pkg;

    // image store geometry and fixed point format
    localparam int MAX_ROWS  = 256;
    localparam int MAX_COLS  = 256;
    localparam int FRAC_BITS = 16;

    // field widths
    localparam int PIX_W      = 8;
    localparam int POS_W      = 8;
    localparam int COEF_W     = 24;
    localparam int SHIFT_W    = 26;
    localparam int DIM_W      = 9;
    localparam int CFG_DATA_W = 26;
    localparam int CFG_IDX_W  = 3;

    // derived widths
    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ROW_AW = $clog2(MAX_ROWS);
    localparam int COL_AW = $clog2(MAX_COLS);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int RDIM_W = $clog2(MAX_ROWS + 1);
    localparam int CDIM_W = $clog2(MAX_COLS + 1);
    localparam int PROD_W = POS_W + 1 + COEF_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int LIM_W  = ((RDIM_W > CDIM_W) ? RDIM_W : CDIM_W) + FRAC_BITS;
    localparam int CMP_W  = ((SUM_W > LIM_W) ? SUM_W : LIM_W) + 1;

    // queues and pipeline
    localparam int ITEM_Q_DEPTH = 4;
    localparam int OUT_Q_DEPTH  = 8;
    localparam int BACK_STAGES  = 4;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_MAP  = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_ROW_TO_Y = 3'd0,
        CFG_COEF_ROW_TO_X = 3'd1,
        CFG_COEF_COL_TO_Y = 3'd2,
        CFG_COEF_COL_TO_X = 3'd3,
        CFG_SHIFT_Y       = 3'd4,
        CFG_SHIFT_X       = 3'd5,
        CFG_IMAGE_ROWS    = 3'd6,
        CFG_IMAGE_COLS    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0]  coef_row_to_y;
        logic signed [COEF_W-1:0]  coef_row_to_x;
        logic signed [COEF_W-1:0]  coef_col_to_y;
        logic signed [COEF_W-1:0]  coef_col_to_x;
        logic signed [SHIFT_W-1:0] shift_y;
        logic signed [SHIFT_W-1:0] shift_x;
        logic [DIM_W-1:0]          image_rows;
        logic [DIM_W-1:0]          image_cols;
    } t_cfg;

    typedef struct packed {
        t_op              op;
        logic [POS_W-1:0] row_in;
        logic [POS_W-1:0] col_in;
        logic [PIX_W-1:0] pixel_in;
    } t_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             outside;
        logic [POS_W-1:0] dest_row;
        logic [POS_W-1:0] dest_col;
    } t_result;

endpackage

/* hdl/awarp_cfg.sv */
// ----------------------------------------------------------------------------
// awarp_cfg
// transform and image size registers behind a plain write port
// ----------------------------------------------------------------------------
module awarp_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [awarp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [awarp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output awarp_pkg::t_cfg                     o_cfg
);
    import awarp_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_COEF_ROW_TO_Y: n_cfg.coef_row_to_y = i_cfg_data[COEF_W-1:0];
                CFG_COEF_ROW_TO_X: n_cfg.coef_row_to_x = i_cfg_data[COEF_W-1:0];
                CFG_COEF_COL_TO_Y: n_cfg.coef_col_to_y = i_cfg_data[COEF_W-1:0];
                CFG_COEF_COL_TO_X: n_cfg.coef_col_to_x = i_cfg_data[COEF_W-1:0];
                CFG_SHIFT_Y:       n_cfg.shift_y       = i_cfg_data[SHIFT_W-1:0];
                CFG_SHIFT_X:       n_cfg.shift_x       = i_cfg_data[SHIFT_W-1:0];
                CFG_IMAGE_ROWS:    n_cfg.image_rows    = i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_COLS:    n_cfg.image_cols    = i_cfg_data[DIM_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_row_to_y <= COEF_W'(1 << FRAC_BITS);
            r_cfg.coef_row_to_x <= '0;
            r_cfg.coef_col_to_y <= '0;
            r_cfg.coef_col_to_x <= COEF_W'(1 << FRAC_BITS);
            r_cfg.shift_y       <= '0;
            r_cfg.shift_x       <= '0;
            r_cfg.image_rows    <= DIM_W'(MAX_ROWS);
            r_cfg.image_cols    <= DIM_W'(MAX_COLS);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/awarp_front.sv */
// ----------------------------------------------------------------------------
// awarp_front
// input register; classifies items and drops loads outside the store
// ----------------------------------------------------------------------------
module awarp_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            i_op,
    input  logic [awarp_pkg::POS_W-1:0]     i_row_in,
    input  logic [awarp_pkg::POS_W-1:0]     i_col_in,
    input  logic [awarp_pkg::PIX_W-1:0]     i_pixel_in,
    output logic                            o_item_valid,
    output awarp_pkg::t_item                o_item,
    input  logic                            i_item_ready
);
    import awarp_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  accept;
    logic  load_ok;
    logic  keep;

    assign full    = r_valid && !i_item_ready;
    assign accept  = push && !full;
    assign load_ok = (32'(i_row_in) < MAX_ROWS) && (32'(i_col_in) < MAX_COLS);
    assign keep    = (t_op'(i_op) == OP_MAP) || load_ok;

    always_comb begin
        n_valid = r_valid;
        if (r_valid && i_item_ready) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid = keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.op       <= t_op'(i_op);
            r_item.row_in   <= i_row_in;
            r_item.col_in   <= i_col_in;
            r_item.pixel_in <= i_pixel_in;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

/* hdl/awarp_item_q.sv */
// ----------------------------------------------------------------------------
// awarp_item_q
// short item queue between front and back
// ----------------------------------------------------------------------------
module awarp_item_q (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  awarp_pkg::t_item    i_item,
    output logic                o_ready,
    output logic                o_valid,
    output awarp_pkg::t_item    o_item,
    input  logic                i_pop
);
    import awarp_pkg::*;

    localparam int PTR_W = $clog2(ITEM_Q_DEPTH);
    localparam int CNT_W = $clog2(ITEM_Q_DEPTH + 1);

    t_item            r_q [ITEM_Q_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_ready = r_cnt != CNT_W'(ITEM_Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_q[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(ITEM_Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(ITEM_Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wptr] <= i_item;
        end
    end

endmodule

/* hdl/awarp_back.sv */
// ----------------------------------------------------------------------------
// awarp_back
// coordinate pipeline, image store and result queue
// ----------------------------------------------------------------------------
module awarp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  awarp_pkg::t_cfg     i_cfg,
    input  logic                i_item_valid,
    input  awarp_pkg::t_item    i_item,
    output logic                o_item_pop,
    output logic                o_res_valid,
    output awarp_pkg::t_result  o_res,
    input  logic                i_res_pop
);
    import awarp_pkg::*;

    localparam int OPTR_W = $clog2(OUT_Q_DEPTH);
    localparam int OCNT_W = $clog2(OUT_Q_DEPTH + 1);
    localparam int INF_W  = $clog2(BACK_STAGES + 1);
    localparam int CRED_W = ((OCNT_W > INF_W) ? OCNT_W : INF_W) + 1;

    // issue
    logic              issue;
    logic              issue_map;
    logic              credit_ok;
    logic [INF_W-1:0]  r_inflight;
    logic [INF_W-1:0]  n_inflight;

    // stage 1: products
    logic                     r1_valid;
    t_item                    r1_item;
    logic signed [PROD_W-1:0] r1_p_ry;
    logic signed [PROD_W-1:0] r1_p_rx;
    logic signed [PROD_W-1:0] r1_p_cy;
    logic signed [PROD_W-1:0] r1_p_cx;

    // stage 2: source coordinates
    logic                    r2_valid;
    t_item                   r2_item;
    logic signed [SUM_W-1:0] r2_sy;
    logic signed [SUM_W-1:0] r2_sx;

    // range check and addressing
    logic [RDIM_W-1:0]       rows_c;
    logic [CDIM_W-1:0]       cols_c;
    logic [CMP_W-1:0]        lim_y;
    logic [CMP_W-1:0]        lim_x;
    logic signed [CMP_W-1:0] sy_ext;
    logic signed [CMP_W-1:0] sx_ext;
    logic                    outside;
    logic [ROW_AW-1:0]       iy;
    logic [COL_AW-1:0]       ix;
    logic [ADDR_W-1:0]       addr;

    // stage 3: store access
    logic              r3_valid;
    t_op               r3_op;
    logic [ADDR_W-1:0] r3_addr;
    logic              r3_outside;
    logic [POS_W-1:0]  r3_row;
    logic [POS_W-1:0]  r3_col;
    logic [PIX_W-1:0]  r3_pix;

    // stage 4: read data
    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_mem_q;
    logic             r4_valid;
    logic             r4_outside;
    logic [POS_W-1:0] r4_row;
    logic [POS_W-1:0] r4_col;

    // result queue
    t_result           r_oq [OUT_Q_DEPTH];
    logic [OPTR_W-1:0] r_owptr;
    logic [OPTR_W-1:0] r_orptr;
    logic [OCNT_W-1:0] r_ocnt;
    logic [OCNT_W-1:0] n_ocnt;
    logic              res_pop;
    t_result           res_in;

    // issue a map only when the result queue has room for it and every map in flight
    assign credit_ok = (CRED_W'(r_ocnt) + CRED_W'(r_inflight)) < CRED_W'(OUT_Q_DEPTH);
    assign issue     = i_item_valid && ((i_item.op == OP_LOAD) || credit_ok);
    assign issue_map = issue && (i_item.op == OP_MAP);
    assign o_item_pop = issue;

    always_comb begin
        case ({issue_map, r4_valid})
            2'b10:   n_inflight = r_inflight + 1'b1;
            2'b01:   n_inflight = r_inflight - 1'b1;
            default: n_inflight = r_inflight;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid   <= 1'b0;
            r2_valid   <= 1'b0;
            r3_valid   <= 1'b0;
            r4_valid   <= 1'b0;
            r_inflight <= '0;
        end else begin
            r1_valid   <= issue;
            r2_valid   <= r1_valid;
            r3_valid   <= r2_valid;
            r4_valid   <= r3_valid && (r3_op == OP_MAP);
            r_inflight <= n_inflight;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_item <= i_item;
        r1_p_ry <= $signed({1'b0, i_item.row_in}) * i_cfg.coef_row_to_y;
        r1_p_rx <= $signed({1'b0, i_item.row_in}) * i_cfg.coef_row_to_x;
        r1_p_cy <= $signed({1'b0, i_item.col_in}) * i_cfg.coef_col_to_y;
        r1_p_cx <= $signed({1'b0, i_item.col_in}) * i_cfg.coef_col_to_x;
    end

    always_ff @(posedge i_clk) begin
        r2_item <= r1_item;
        r2_sy   <= SUM_W'(r1_p_ry) + SUM_W'(r1_p_cy) + SUM_W'(i_cfg.shift_y);
        r2_sx   <= SUM_W'(r1_p_rx) + SUM_W'(r1_p_cx) + SUM_W'(i_cfg.shift_x);
    end

    always_comb begin
        rows_c = (32'(i_cfg.image_rows) > MAX_ROWS) ? RDIM_W'(MAX_ROWS)
                                                    : RDIM_W'(i_cfg.image_rows);
        cols_c = (32'(i_cfg.image_cols) > MAX_COLS) ? CDIM_W'(MAX_COLS)
                                                    : CDIM_W'(i_cfg.image_cols);
        lim_y  = CMP_W'(rows_c - RDIM_W'(1)) << FRAC_BITS;
        lim_x  = CMP_W'(cols_c - CDIM_W'(1)) << FRAC_BITS;
        sy_ext = CMP_W'(r2_sy);
        sx_ext = CMP_W'(r2_sx);
        outside = (rows_c == '0) || (cols_c == '0) || sy_ext[CMP_W-1] || sx_ext[CMP_W-1]
                  || ($unsigned(sy_ext) > lim_y) || ($unsigned(sx_ext) > lim_x);
        iy = r2_sy[FRAC_BITS +: ROW_AW];
        ix = r2_sx[FRAC_BITS +: COL_AW];
        if (r2_item.op == OP_LOAD) begin
            addr = ADDR_W'(ADDR_W'(ROW_AW'(r2_item.row_in)) * ADDR_W'(MAX_COLS)
                           + ADDR_W'(COL_AW'(r2_item.col_in)));
        end else begin
            addr = ADDR_W'(ADDR_W'(iy) * ADDR_W'(MAX_COLS) + ADDR_W'(ix));
        end
    end

    always_ff @(posedge i_clk) begin
        r3_op      <= r2_item.op;
        r3_addr    <= addr;
        r3_outside <= outside;
        r3_row     <= r2_item.row_in;
        r3_col     <= r2_item.col_in;
        r3_pix     <= r2_item.pixel_in;
    end

    // image store, one access per item
    always_ff @(posedge i_clk) begin
        if (r3_valid && (r3_op == OP_LOAD)) begin
            r_mem[r3_addr] <= r3_pix;
        end
        r_mem_q <= r_mem[r3_addr];
    end

    always_ff @(posedge i_clk) begin
        r4_outside <= r3_outside;
        r4_row     <= r3_row;
        r4_col     <= r3_col;
    end

    // result queue
    assign res_in.pixel_out = r4_outside ? '0 : r_mem_q;
    assign res_in.outside   = r4_outside;
    assign res_in.dest_row  = r4_row;
    assign res_in.dest_col  = r4_col;

    assign o_res_valid = r_ocnt != '0;
    assign o_res       = r_oq[r_orptr];
    assign res_pop     = i_res_pop && o_res_valid;

    always_comb begin
        case ({r4_valid, res_pop})
            2'b10:   n_ocnt = r_ocnt + 1'b1;
            2'b01:   n_ocnt = r_ocnt - 1'b1;
            default: n_ocnt = r_ocnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owptr <= '0;
            r_orptr <= '0;
            r_ocnt  <= '0;
        end else begin
            r_ocnt <= n_ocnt;
            if (r4_valid) begin
                r_owptr <= (r_owptr == OPTR_W'(OUT_Q_DEPTH - 1)) ? '0 : r_owptr + 1'b1;
            end
            if (res_pop) begin
                r_orptr <= (r_orptr == OPTR_W'(OUT_Q_DEPTH - 1)) ? '0 : r_orptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r4_valid) begin
            r_oq[r_owptr] <= res_in;
        end
    end

endmodule

/* hdl/affine_backward_warp.sv */
// ----------------------------------------------------------------------------
// affine_backward_warp
// inverse-mapping affine warp with nearest pixel fetch
//
// Load items write one 8-bit pixel into the source image store; map items
// take a destination row and column, form the source coordinate in Q.16
// fixed point from the configured matrix and translation, and return the
// stored pixel at the truncated coordinate, or outside with pixel zero when
// the coordinate falls off the image. One item is accepted every cycle while
// results are taken; a map result passes the input register, the item queue,
// four back stages (products, sums, range check and address, store read) and
// then the result queue. Loads give no result. The image store has a single
// port that each item uses once, in order, so a map always sees every earlier
// load. Store entries are not cleared at reset. Configuration must be written
// only while no item is in flight; the user is bound by this, the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
module affine_backward_warp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [awarp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [awarp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic                            i_op,
    input  logic [awarp_pkg::POS_W-1:0]     i_row_in,
    input  logic [awarp_pkg::POS_W-1:0]     i_col_in,
    input  logic [awarp_pkg::PIX_W-1:0]     i_pixel_in,
    output logic                            empty,
    input  logic                            pop,
    output logic [awarp_pkg::PIX_W-1:0]     o_pixel_out,
    output logic                            o_outside,
    output logic [awarp_pkg::POS_W-1:0]     o_dest_row,
    output logic [awarp_pkg::POS_W-1:0]     o_dest_col
);
    import awarp_pkg::*;

    t_cfg    cfg;
    logic    fr_valid;
    t_item   fr_item;
    logic    q_ready;
    logic    q_valid;
    t_item   q_item;
    logic    q_pop;
    logic    res_valid;
    t_result res;

    awarp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    awarp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_op         (i_op),
        .i_row_in     (i_row_in),
        .i_col_in     (i_col_in),
        .i_pixel_in   (i_pixel_in),
        .o_item_valid (fr_valid),
        .o_item       (fr_item),
        .i_item_ready (q_ready)
    );

    awarp_item_q u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_item  (fr_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    awarp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_item_pop   (q_pop),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_pop    (pop)
    );

    assign empty       = !res_valid;
    assign o_pixel_out = res.pixel_out;
    assign o_outside   = res.outside;
    assign o_dest_row  = res.dest_row;
    assign o_dest_col  = res.dest_col;

endmodule
